[rtl/bbsf_pkg.sv]
// Shared types, sizes and codes for the bounded byte stream FIFO.
package bbsf_pkg;

	// Storage depth in bytes and the longest run that one request may return.
	localparam int DEPTH   = 4096;
	localparam int MAX_RUN = 64;

	// Fixed field widths of the capacity, request and response words.
	localparam int CFG_W   = 13;
	localparam int LEN_W   = 7;
	localparam int STAT_W  = 13;
	localparam int TOT_W   = 64;

	// Widths that follow from the depth and the run length.
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int OCC_W   = $clog2(DEPTH + 1);
	localparam int RUN_W   = $clog2(MAX_RUN + 1);
	localparam int NCMP_W  = (OCC_W > RUN_W) ? OCC_W : RUN_W;
	localparam int CCMP_W  = (OCC_W > CFG_W) ? OCC_W : CFG_W;

	// Capacity limit after reset.
	localparam int CAP_RESET = 4096;

	// Request codes.
	typedef enum logic [2:0] {
		REQ_WRITE = 3'd0,
		REQ_PEEK  = 3'd1,
		REQ_POP   = 3'd2,
		REQ_READ  = 3'd3,
		REQ_END   = 3'd4,
		REQ_ERROR = 3'd5
	} req_code_t;

	// Controller states.
	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} bbsf_state_t;

	// One request word.
	typedef struct packed {
		logic [2:0]       req_type;
		logic [7:0]       write_byte;
		logic [LEN_W-1:0] request_length;
	} req_item_t;

	// One response word.
	typedef struct packed {
		logic [7:0]        out_byte;
		logic              byte_valid;
		logic              last_of_run;
		logic              write_accepted;
		logic [STAT_W-1:0] bytes_buffered;
		logic [STAT_W-1:0] space_left;
		logic              ended_flag;
		logic              end_of_stream;
		logic [TOT_W-1:0]  total_written;
		logic [TOT_W-1:0]  total_read;
	} rsp_item_t;

endpackage

[rtl/bbsf_ifs.sv]
// Handshake channels for requests, responses and the capacity register.
interface bbsf_req_if;
	import bbsf_pkg::*;
	logic      valid;
	logic      ready;
	req_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface bbsf_rsp_if;
	import bbsf_pkg::*;
	logic      valid;
	logic      ready;
	rsp_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface bbsf_cfg_if;
	import bbsf_pkg::*;
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/bbsf_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module bbsf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port, and a read port whose data holds while re is low.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/bbsf_ctrl.sv]
// Request decoder, pointer and count state, read run sequencer and response register.
module bbsf_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [bbsf_pkg::OCC_W-1:0] cap,
	bbsf_req_if.sink                   req,
	bbsf_rsp_if.source                 rsp
);
	import bbsf_pkg::*;

	bbsf_state_t       state_q, state_d;
	logic [ADDR_W-1:0] head_q, tail_q, rptr_q;
	logic [OCC_W-1:0]  occ_q;
	logic              closed_q, err_q;
	logic [TOT_W-1:0]  wtot_q, rtot_q;
	logic [RUN_W-1:0]  rem_q;
	logic              s1_vld_s1, s1_last_s1;
	logic              o_vld_q, o_bv_q, o_last_q, o_acc_q;
	logic [7:0]        o_byte_q;

	req_item_t         p;
	logic              o_free, acc_in, s1_adv, rd_en, in_rdy;
	logic              is_wr, is_pop, is_run_req, wr_ok;
	logic [RUN_W-1:0]  len_c, n;
	logic [ADDR_W:0]   hsum;
	logic [ADDR_W-1:0] head_nx, tail_inc, rptr_inc;
	logic [OCC_W-1:0]  space;
	logic              ram_we;
	logic [7:0]        ram_rdata;
	logic [ADDR_W:0]   tchk_sum;
	logic [ADDR_W-1:0] tail_exp;

	assign p = req.payload;

	// Request decode and run length: clamp to the run limit, then to occupancy.
	always_comb begin
		is_wr      = (p.req_type == REQ_WRITE);
		is_pop     = (p.req_type == REQ_POP);
		is_run_req = (p.req_type == REQ_PEEK) || (p.req_type == REQ_READ);
		wr_ok      = !closed_q && !err_q && (occ_q < cap);
		len_c      = (p.request_length > LEN_W'(MAX_RUN)) ? RUN_W'(MAX_RUN)
		                                                  : RUN_W'(p.request_length);
		n          = (NCMP_W'(len_c) > NCMP_W'(occ_q)) ? RUN_W'(occ_q) : len_c;
	end

	// Pointer arithmetic with wrap at the storage depth, and space left under the capacity.
	always_comb begin
		hsum     = {1'b0, head_q} + (ADDR_W + 1)'(n);
		head_nx  = (hsum >= (ADDR_W + 1)'(DEPTH)) ? ADDR_W'(hsum - (ADDR_W + 1)'(DEPTH))
		                                          : ADDR_W'(hsum);
		tail_inc = (tail_q == ADDR_W'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
		rptr_inc = (rptr_q == ADDR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
		space    = (cap > occ_q) ? cap - occ_q : '0;
	end

	// Next state, input ready and read issue.
	always_comb begin
		o_free  = !o_vld_q || rsp.ready;
		s1_adv  = s1_vld_s1 && o_free;
		in_rdy  = 1'b0;
		rd_en   = 1'b0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				in_rdy = o_free;
				if (req.valid && o_free && is_run_req && (n != '0)) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				rd_en = (rem_q != '0) && (!s1_vld_s1 || s1_adv);
				if ((rem_q == '0) && (!s1_vld_s1 || s1_adv)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		acc_in = req.valid && in_rdy;
		ram_we = acc_in && is_wr && wr_ok;
	end

	assign req.ready = in_rdy;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Stream state: pointers, occupancy, flags and totals change only at acceptance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			occ_q    <= '0;
			closed_q <= 1'b0;
			err_q    <= 1'b0;
			wtot_q   <= '0;
			rtot_q   <= '0;
		end else if (acc_in) begin
			case (p.req_type)
				REQ_WRITE: begin
					if (wr_ok) begin
						tail_q <= tail_inc;
						occ_q  <= occ_q + 1'b1;
						wtot_q <= wtot_q + 1'b1;
					end
				end
				REQ_POP, REQ_READ: begin
					head_q <= head_nx;
					occ_q  <= occ_q - OCC_W'(n);
					rtot_q <= rtot_q + TOT_W'(n);
				end
				REQ_END: begin
					closed_q <= 1'b1;
				end
				REQ_ERROR: begin
					err_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Run sequencer: one RAM read per cycle while the response side keeps up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rptr_q     <= '0;
			rem_q      <= '0;
			s1_vld_s1  <= 1'b0;
			s1_last_s1 <= 1'b0;
		end else begin
			if (acc_in) begin
				rptr_q <= head_q;
				rem_q  <= is_run_req ? n : '0;
			end else if (rd_en) begin
				rptr_q <= rptr_inc;
				rem_q  <= rem_q - 1'b1;
			end
			if (rd_en) begin
				s1_vld_s1  <= 1'b1;
				s1_last_s1 <= (rem_q == RUN_W'(1));
			end else if (s1_adv) begin
				s1_vld_s1 <= 1'b0;
			end
		end
	end

	// Response register: status words at acceptance, stream bytes from the RAM.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_vld_q  <= 1'b0;
			o_bv_q   <= 1'b0;
			o_last_q <= 1'b0;
			o_acc_q  <= 1'b0;
		end else if (acc_in) begin
			o_vld_q  <= !is_pop && !(is_run_req && (n != '0));
			o_bv_q   <= 1'b0;
			o_last_q <= 1'b1;
			o_acc_q  <= is_wr && wr_ok;
		end else if (s1_adv) begin
			o_vld_q  <= 1'b1;
			o_bv_q   <= 1'b1;
			o_last_q <= s1_last_s1;
			o_acc_q  <= 1'b0;
		end else if (rsp.ready) begin
			o_vld_q <= 1'b0;
		end
	end

	// Response byte.
	always_ff @(posedge clk) begin
		if (acc_in) begin
			o_byte_q <= '0;
		end else if (s1_adv) begin
			o_byte_q <= ram_rdata;
		end
	end

	// Byte store.
	bbsf_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata (p.write_byte),
		.re    (rd_en),
		.raddr (rptr_q),
		.rdata (ram_rdata)
	);

	// Status fields reflect the stream state after the request being answered.
	assign rsp.valid                  = o_vld_q;
	assign rsp.payload.out_byte       = o_byte_q;
	assign rsp.payload.byte_valid     = o_bv_q;
	assign rsp.payload.last_of_run    = o_last_q;
	assign rsp.payload.write_accepted = o_acc_q;
	assign rsp.payload.bytes_buffered = STAT_W'(occ_q);
	assign rsp.payload.space_left     = STAT_W'(space);
	assign rsp.payload.ended_flag     = closed_q;
	assign rsp.payload.end_of_stream  = closed_q && (occ_q == '0);
	assign rsp.payload.total_written  = wtot_q;
	assign rsp.payload.total_read     = rtot_q;

	// Expected tail position, for checking the pointer bookkeeping.
	always_comb begin
		tchk_sum = {1'b0, head_q} + (ADDR_W + 1)'(occ_q);
		tail_exp = (tchk_sum >= (ADDR_W + 1)'(DEPTH))
		           ? ADDR_W'(tchk_sum - (ADDR_W + 1)'(DEPTH)) : ADDR_W'(tchk_sum);
	end

	// The tail always sits occupancy bytes past the head.
	a_tail_track: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q == tail_exp)
		else $error("tail pointer out of step with head and occupancy");

	// Occupancy never exceeds the storage depth.
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(DEPTH))
		else $error("occupancy beyond storage depth");

	// A RAM read always yields a staged byte in the next cycle.
	a_read_stage: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> s1_vld_s1)
		else $error("read issued without staged data");

	// No run work remains while requests are being taken.
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !s1_vld_s1 && (rem_q == '0))
		else $error("run work left over in idle");

	// Storage is never written while a run reads it.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == ST_IDLE && !rd_en)
		else $error("store written during a read run");

endmodule

[rtl/bounded_byte_stream_fifo_core.sv]
// Top level of the bounded byte stream FIFO: capacity register and controller.
// Write, status and empty requests answer with one word one cycle after acceptance.
// Peek and read of n bytes take each byte from the single RAM read port through the read
// pointer, RAM read and response registers; the next request is taken after the run.
// Non-run requests and run bytes sustain one per cycle while responses are taken.
// Reset clears pointers, counts, flags and totals and sets the capacity to 4096 at once.
module bounded_byte_stream_fifo_core (
	input  logic       clk,
	input  logic       arst_n,
	bbsf_req_if.sink   req,
	bbsf_rsp_if.source rsp,
	bbsf_cfg_if.sink   cfg
);
	import bbsf_pkg::*;

	logic [OCC_W-1:0] cap_q;
	logic [OCC_W-1:0] cap_wr;
	logic [OCC_W-1:0] cap_rst;

	// The capacity is stored already clamped to the storage depth.
	always_comb begin
		cap_wr  = (CCMP_W'(cfg.data) >= CCMP_W'(DEPTH)) ? OCC_W'(DEPTH) : OCC_W'(cfg.data);
		cap_rst = (CAP_RESET >= DEPTH) ? OCC_W'(DEPTH) : OCC_W'(CAP_RESET);
	end

	assign cfg.ready = 1'b1;

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= cap_rst;
		end else if (cfg.valid) begin
			cap_q <= cap_wr;
		end
	end

	// Stream controller with its byte store.
	bbsf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.cap    (cap_q),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the bounded byte stream FIFO core.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bbsf_pkg::*;

	// Request codes the block does not define; they must leave the state alone.
	localparam logic [2:0] REQ_SPARE_A = 3'd6;
	localparam logic [2:0] REQ_SPARE_B = 3'd7;
	localparam logic [LEN_W-1:0] LEN_ALL = '1;
	localparam int SETTLE_CYCLES = 6;
	localparam int STALL_LIMIT   = 3000;
	localparam int HOLD_CYCLES   = 300;

	logic clk;
	logic arst_n;

	bbsf_req_if req_ch ();
	bbsf_rsp_if rsp_ch ();
	bbsf_cfg_if cfg_ch ();

	bounded_byte_stream_fifo_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Shadow copy of the FIFO contents, counters and capacity register.
	logic [7:0]       shadow_bytes [DEPTH];
	int               shadow_head    = 0;
	int               shadow_count   = 0;
	logic             shadow_closed  = 1'b0;
	logic             shadow_error   = 1'b0;
	logic [TOT_W-1:0] shadow_written = '0;
	logic [TOT_W-1:0] shadow_read    = '0;
	logic [CFG_W-1:0] shadow_cap     = CFG_W'(CAP_RESET);

	// Response words predicted but not yet seen, oldest first.
	rsp_item_t responses_due [$];

	int mismatch_count = 0;
	int stalled_cycles = 0;
	int hold_request   = 0;
	bit sender_gaps    = 1'b1;
	bit receiver_gaps  = 1'b1;

	// Free room under the effective capacity, which never exceeds the depth.
	function automatic int free_space();
		int eff_cap;
		eff_cap = (int'(shadow_cap) < DEPTH) ? int'(shadow_cap) : DEPTH;
		return (eff_cap > shadow_count) ? eff_cap - shadow_count : 0;
	endfunction

	function automatic rsp_item_t status_word(input logic [7:0] data, input logic data_ok,
			input logic last, input logic stored);
		rsp_item_t w;
		w.out_byte       = data;
		w.byte_valid     = data_ok;
		w.last_of_run    = last;
		w.write_accepted = stored;
		w.bytes_buffered = STAT_W'(shadow_count);
		w.space_left     = STAT_W'(free_space());
		w.ended_flag     = shadow_closed;
		w.end_of_stream  = shadow_closed && (shadow_count == 0);
		w.total_written  = shadow_written;
		w.total_read     = shadow_read;
		return w;
	endfunction

	// Apply one accepted request to the shadow state and queue its response words.
	function automatic void compute_responses(input req_item_t r);
		logic [7:0] run_bytes [MAX_RUN];
		int n;
		logic stored;
		case (r.req_type)
			REQ_WRITE: begin
				stored = !shadow_closed && !shadow_error && (free_space() > 0);
				if (stored) begin
					shadow_bytes[(shadow_head + shadow_count) % DEPTH] = r.write_byte;
					shadow_count++;
					shadow_written++;
				end
				responses_due.push_back(status_word(8'h00, 1'b0, 1'b1, stored));
			end
			REQ_PEEK, REQ_POP, REQ_READ: begin
				n = int'(r.request_length);
				if (n > MAX_RUN) n = MAX_RUN;
				if (n > shadow_count) n = shadow_count;
				for (int i = 0; i < n; i++)
					run_bytes[i] = shadow_bytes[(shadow_head + i) % DEPTH];
				if (r.req_type != REQ_PEEK) begin
					shadow_head  = (shadow_head + n) % DEPTH;
					shadow_count -= n;
					shadow_read  += TOT_W'(n);
				end
				if (r.req_type != REQ_POP) begin
					if (n == 0)
						responses_due.push_back(status_word(8'h00, 1'b0, 1'b1, 1'b0));
					for (int i = 0; i < n; i++)
						responses_due.push_back(status_word(run_bytes[i], 1'b1, i == n - 1,
							1'b0));
				end
			end
			REQ_END: begin
				shadow_closed = 1'b1;
				responses_due.push_back(status_word(8'h00, 1'b0, 1'b1, 1'b0));
			end
			REQ_ERROR: begin
				shadow_error = 1'b1;
				responses_due.push_back(status_word(8'h00, 1'b0, 1'b1, 1'b0));
			end
			default: begin
				responses_due.push_back(status_word(8'h00, 1'b0, 1'b1, 1'b0));
			end
		endcase
	endfunction

	function automatic req_item_t make_req(input logic [2:0] code, input logic [7:0] data,
			input logic [LEN_W-1:0] len);
		req_item_t r;
		r.req_type       = code;
		r.write_byte     = data;
		r.request_length = len;
		return r;
	endfunction

	// Random request: mostly writes and short reads, now and then a long or spare one.
	function automatic req_item_t random_request();
		int pick;
		logic [2:0] code;
		logic [LEN_W-1:0] len;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			code = REQ_WRITE;
		else if (pick < 62)
			code = REQ_PEEK;
		else if (pick < 72)
			code = REQ_POP;
		else if (pick < 94)
			code = REQ_READ;
		else if (pick < 97)
			code = REQ_SPARE_A;
		else
			code = REQ_SPARE_B;
		if ($urandom_range(0, 7) == 0)
			len = LEN_W'($urandom_range(0, 127));
		else
			len = LEN_W'($urandom_range(0, 16));
		return make_req(code, 8'($urandom), len);
	endfunction

	// Clock.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Offer one request word, optionally after a gap, and wait for it to be taken.
	task automatic send_word(input req_item_t r);
		if (sender_gaps && $urandom_range(0, 4) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.payload <= r;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		compute_responses(r);
	endtask

	// Stop offering, wait until every predicted word has arrived, then let the block settle.
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (responses_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CFG_W-1:0] value);
		wait_idle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
		shadow_cap = value;
	endtask

	// Byte extremes, peek versus read versus pop, clamping, empty requests, spare codes.
	task automatic test_basic_ops();
		send_word(make_req(REQ_WRITE, 8'h00, '0));
		send_word(make_req(REQ_WRITE, 8'hFF, LEN_ALL));
		send_word(make_req(REQ_WRITE, 8'hA5, 7'h2A));
		send_word(make_req(REQ_WRITE, 8'h5A, 7'h55));
		send_word(make_req(REQ_PEEK, 8'h00, 7'd2));
		send_word(make_req(REQ_PEEK, 8'hFF, 7'd0));
		send_word(make_req(REQ_READ, 8'h00, 7'd1));
		send_word(make_req(REQ_POP, 8'h00, 7'd1));
		send_word(make_req(REQ_READ, 8'h00, LEN_ALL));
		send_word(make_req(REQ_READ, 8'h00, 7'd5));
		send_word(make_req(REQ_PEEK, 8'h00, 7'd3));
		send_word(make_req(REQ_POP, 8'h00, 7'd4));
		send_word(make_req(REQ_SPARE_A, 8'hFF, LEN_ALL));
		send_word(make_req(REQ_SPARE_B, 8'h00, '0));
		wait_idle();
	endtask

	// Full at a small limit, a limit below the fill level, zero, and one above the depth.
	task automatic test_capacity_limits();
		write_capacity(CFG_W'(3));
		repeat (4) send_word(make_req(REQ_WRITE, 8'($urandom), '0));
		write_capacity('0);
		send_word(make_req(REQ_WRITE, 8'h77, '0));
		send_word(make_req(REQ_READ, 8'h00, LEN_ALL));
		write_capacity('1);
		repeat (2) send_word(make_req(REQ_WRITE, 8'($urandom), '0));
		send_word(make_req(REQ_PEEK, 8'h00, 7'd64));
		write_capacity(CFG_W'(1));
		send_word(make_req(REQ_WRITE, 8'h3C, '0));
		send_word(make_req(REQ_READ, 8'h00, 7'd2));
		write_capacity(CFG_W'(CAP_RESET));
	endtask

	// Responses hold off while writes keep coming; runs clamp at the maximum, then at occupancy.
	task automatic test_backpressure();
		hold_request = HOLD_CYCLES;
		repeat (66) send_word(make_req(REQ_WRITE, 8'($urandom), 7'($urandom)));
		send_word(make_req(REQ_PEEK, 8'h00, LEN_ALL));
		send_word(make_req(REQ_READ, 8'h00, 7'd100));
		send_word(make_req(REQ_READ, 8'h00, LEN_ALL));
		wait_idle();
	endtask

	task automatic test_random(input logic [CFG_W-1:0] cap, input int count);
		write_capacity(cap);
		repeat (count) send_word(random_request());
		wait_idle();
	endtask

	// Sticky end of input and error flags, end of stream once drained.
	task automatic test_end_and_error();
		while (shadow_count != 0) send_word(make_req(REQ_READ, 8'h00, 7'd64));
		repeat (3) send_word(make_req(REQ_WRITE, 8'($urandom), '0));
		send_word(make_req(REQ_END, 8'h00, '0));
		send_word(make_req(REQ_WRITE, 8'hC3, '0));
		send_word(make_req(REQ_PEEK, 8'h00, LEN_ALL));
		send_word(make_req(REQ_READ, 8'h00, 7'd2));
		send_word(make_req(REQ_READ, 8'h00, 7'd1));
		send_word(make_req(REQ_READ, 8'h00, 7'd4));
		send_word(make_req(REQ_POP, 8'h00, 7'd4));
		send_word(make_req(REQ_ERROR, 8'h00, '0));
		send_word(make_req(REQ_WRITE, 8'h81, '0));
		send_word(make_req(REQ_END, 8'h00, '0));
		send_word(make_req(REQ_SPARE_A, 8'h00, '0));
		wait_idle();
	endtask

	// Response side: random stall bursts, plus a long hold-off when a test asks for one.
	initial begin
		int stall;
		rsp_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_request > 0) begin
				stall = hold_request;
				hold_request = 0;
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Compare every accepted response word with the oldest prediction.
	always @(posedge clk) begin : check_responses
		rsp_item_t got;
		rsp_item_t want;
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			got = rsp_ch.payload;
			if (responses_due.size() == 0) begin
				$display("%0t: unexpected response word %h", $time, got);
				mismatch_count++;
			end else begin
				want = responses_due.pop_front();
				check_field("out_byte", 64'(want.out_byte), 64'(got.out_byte));
				check_field("byte_valid", 64'(want.byte_valid), 64'(got.byte_valid));
				check_field("last_of_run", 64'(want.last_of_run), 64'(got.last_of_run));
				check_field("write_accepted", 64'(want.write_accepted),
					64'(got.write_accepted));
				check_field("bytes_buffered", 64'(want.bytes_buffered),
					64'(got.bytes_buffered));
				check_field("space_left", 64'(want.space_left), 64'(got.space_left));
				check_field("ended_flag", 64'(want.ended_flag), 64'(got.ended_flag));
				check_field("end_of_stream", 64'(want.end_of_stream),
					64'(got.end_of_stream));
				check_field("total_written", want.total_written, got.total_written);
				check_field("total_read", want.total_read, got.total_read);
			end
		end
	end

	// Watchdog on cycles in which no word moves on any channel.
	always @(posedge clk) begin
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
				|| (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
				|| (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
			stalled_cycles = 0;
		else
			stalled_cycles++;
		if (stalled_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Test sequence.
	initial begin
		arst_n         <= 1'b0;
		req_ch.valid   <= 1'b0;
		req_ch.payload <= '0;
		cfg_ch.valid   <= 1'b0;
		cfg_ch.data    <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_ops();
		test_capacity_limits();
		test_backpressure();
		test_random(CFG_W'(CAP_RESET), 5);
		test_random(CFG_W'(12), 4);

		// The tail of the run goes without idling on either side.
		sender_gaps   = 1'b0;
		receiver_gaps = 1'b0;
		test_random('1, 4);
		test_end_and_error();

		wait_idle();
		if (responses_due.size() != 0) begin
			$display("%0t: %0d predicted words never arrived", $time, responses_due.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
